// ===== src/k_way_sorted_merge_unit_macros.svh =====
// Assertion helpers used by the merge unit back end (kwm_back).
// Each macro expects clk_i and rst_ni in scope.
`ifndef K_WAY_SORTED_MERGE_UNIT_MACROS_SVH
`define K_WAY_SORTED_MERGE_UNIT_MACROS_SVH

// Same-cycle implication.
`define KWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kwm_pkg.sv =====
`default_nettype none

package kwm_pkg;

  localparam int ID_W        = 3;
  localparam int VAL_W       = 32;
  localparam int CFG_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_CLOSE  = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [ID_W-1:0]         list_id;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] merged_value;
    logic [ID_W-1:0]         source_list;
    logic                    last_of_run;
    logic                    merge_done;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_DROP,
    OP_CLOSE,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ID_W-1:0]  list_id;
    logic [VAL_W-1:0] value;
  } q_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_PUT,
    S_END
  } back_state_e;

endpackage

`default_nettype wire

// ===== src/kwm_front.sv =====
`default_nettype none

module kwm_front #(
  parameter int LISTS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [kwm_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire kwm_pkg::in_item_t       in_data_i,
  input  wire logic                    q_full_i,
  output logic                         q_push_o,
  output kwm_pkg::q_entry_t            q_data_o,
  output logic [kwm_pkg::CFG_W-1:0]    n_lists_o
);
  import kwm_pkg::*;

  logic [CFG_W-1:0] cfg_q;
  logic [CFG_W-1:0] n_lists;
  logic             in_range;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Clamp the register to 1..LISTS.
  always_comb begin
    if (cfg_q == '0) begin
      n_lists = CFG_W'(1);
    end else if (cfg_q > CFG_W'(LISTS)) begin
      n_lists = CFG_W'(LISTS);
    end else begin
      n_lists = cfg_q;
    end
  end

  assign n_lists_o = n_lists;
  assign in_range  = CFG_W'(in_data_i.list_id) < n_lists;

  always_comb begin
    q_data_o.list_id = in_data_i.list_id;
    q_data_o.value   = in_data_i.value;
    if (in_data_i.action == ACT_APPEND) begin
      q_data_o.op = in_range ? OP_PUSH : OP_DROP;
    end else begin
      q_data_o.op = in_range ? OP_CLOSE : OP_NOP;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

// ===== src/kwm_queue.sv =====
`default_nettype none

module kwm_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire kwm_pkg::q_entry_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output kwm_pkg::q_entry_t      data_o
);
  import kwm_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         entries_q [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == QCW'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/kwm_back.sv =====
`default_nettype none
`include "k_way_sorted_merge_unit_macros.svh"

module kwm_back #(
  parameter int LISTS        = 8,
  parameter int BUFFER_DEPTH = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [kwm_pkg::CFG_W-1:0] n_lists_i,
  input  wire logic                      q_valid_i,
  input  wire kwm_pkg::q_entry_t         q_data_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output kwm_pkg::out_item_t             out_data_o
);
  import kwm_pkg::*;

  localparam int LW        = $clog2(LISTS);
  localparam int PW        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FW        = $clog2(BUFFER_DEPTH + 1);
  localparam int SW        = FW + 1;
  localparam int MEM_DEPTH = LISTS * BUFFER_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int CW        = $clog2(LISTS + 1);

  back_state_e      state_q, state_d;
  logic [FW-1:0]    fill_q [LISTS];
  logic [FW-1:0]    fill_d [LISTS];
  logic [PW-1:0]    rp_q [LISTS];
  logic [PW-1:0]    rp_d [LISTS];
  logic [LISTS-1:0] closed_q, closed_d;

  logic             pend_vld_q, pend_vld_d;
  out_item_t        pend_q, pend_d;
  logic [ID_W-1:0]  item_id_q, item_id_d;
  logic             drop_q, drop_d;

  logic [CW-1:0]    scan_q, scan_d;
  logic             rd_vld_q, rd_vld_d;
  logic [LW-1:0]    rd_list_q, rd_list_d;
  logic [VAL_W-1:0] rd_data_q;
  logic             best_vld_q, best_vld_d;
  logic [VAL_W-1:0] best_val_q, best_val_d;
  logic [LW-1:0]    best_id_q, best_id_d;

  logic             out_vld_q;
  out_item_t        out_q;
  logic             out_push;
  out_item_t        push_data;
  logic             out_free;

  logic [VAL_W-1:0] mem [MEM_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;

  logic [LISTS-1:0] used;
  logic [LISTS-1:0] nonempty;
  logic             blocked, any_data, drained, all_closed, done_cond;
  logic [LW-1:0]    id_idx;
  logic [LW-1:0]    scan_idx;
  logic [SW-1:0]    wsum;
  logic [PW-1:0]    wptr;
  logic             push_ok;

  assign id_idx   = q_data_i.list_id[LW-1:0];
  assign scan_idx = scan_q[LW-1:0];
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < LISTS; i++) begin
      used[i]     = CFG_W'(i) < n_lists_i;
      nonempty[i] = fill_q[i] != '0;
    end
    blocked    = |(used & ~nonempty & ~closed_q);
    any_data   = |(used & nonempty);
    drained    = !any_data;
    all_closed = (closed_q & used) == used;
    done_cond  = !drop_q && drained && all_closed;
  end

  // Circular write slot: (read pointer + fill) wraps at most once.
  always_comb begin
    wsum = SW'(rp_q[id_idx]) + SW'(fill_q[id_idx]);
    if (wsum >= SW'(BUFFER_DEPTH)) begin
      wsum = wsum - SW'(BUFFER_DEPTH);
    end
    wptr = wsum[PW-1:0];
  end

  assign push_ok   = !closed_q[id_idx] && (fill_q[id_idx] < FW'(BUFFER_DEPTH));
  assign mem_waddr = AW'(id_idx) * AW'(BUFFER_DEPTH) + AW'(wptr);
  assign mem_raddr = AW'(scan_idx) * AW'(BUFFER_DEPTH) + AW'(rp_q[scan_idx]);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    rp_d       = rp_q;
    closed_d   = closed_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    item_id_d  = item_id_q;
    drop_d     = drop_q;
    scan_d     = scan_q;
    best_vld_d = best_vld_q;
    best_val_d = best_val_q;
    best_id_d  = best_id_q;
    rd_vld_d   = 1'b0;
    rd_list_d  = scan_idx;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    out_push   = 1'b0;
    push_data  = pend_q;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          item_id_d = q_data_i.list_id;
          drop_d    = 1'b0;
          state_d   = S_CHECK;
          case (q_data_i.op)
            OP_PUSH: begin
              if (push_ok) begin
                mem_we         = 1'b1;
                fill_d[id_idx] = fill_q[id_idx] + FW'(1);
              end else begin
                drop_d  = 1'b1;
                state_d = S_END;
              end
            end
            OP_DROP: begin
              drop_d  = 1'b1;
              state_d = S_END;
            end
            OP_CLOSE: begin
              closed_d[id_idx] = 1'b1;
            end
            default: begin
            end
          endcase
          if (drop_d) begin
            pend_vld_d          = 1'b1;
            pend_d.kind         = KIND_DROP;
            pend_d.merged_value = q_data_i.value;
            pend_d.source_list  = q_data_i.list_id;
            pend_d.last_of_run  = 1'b0;
            pend_d.merge_done   = 1'b0;
          end
        end
      end

      S_CHECK: begin
        if (blocked || !any_data) begin
          state_d = S_END;
        end else begin
          scan_d     = '0;
          best_vld_d = 1'b0;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        // Evaluate the head read in the previous cycle.
        if (rd_vld_q && fill_q[rd_list_q] != '0) begin
          if (!best_vld_q || $signed(rd_data_q) < $signed(best_val_q)) begin
            best_vld_d = 1'b1;
            best_val_d = rd_data_q;
            best_id_d  = rd_list_q;
          end
        end
        if (CFG_W'(scan_q) < n_lists_i) begin
          rd_vld_d = 1'b1;
          scan_d   = scan_q + CW'(1);
        end else begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_push              = 1'b1;
            push_data.last_of_run = 1'b0;
            push_data.merge_done  = 1'b0;
          end
          pend_vld_d            = 1'b1;
          pend_d.kind           = KIND_DATA;
          pend_d.merged_value   = best_val_q;
          pend_d.source_list    = ID_W'(best_id_q);
          pend_d.last_of_run    = 1'b0;
          pend_d.merge_done     = 1'b0;
          fill_d[best_id_q]     = fill_q[best_id_q] - FW'(1);
          rp_d[best_id_q]       = (rp_q[best_id_q] == PW'(BUFFER_DEPTH - 1)) ?
                                  '0 : rp_q[best_id_q] + PW'(1);
          state_d               = S_CHECK;
        end
      end

      S_END: begin
        if (pend_vld_q) begin
          if (out_free) begin
            out_push              = 1'b1;
            push_data.last_of_run = 1'b1;
            push_data.merge_done  = done_cond;
            pend_vld_d            = 1'b0;
            if (done_cond) begin
              closed_d = '0;
            end
            state_d = S_IDLE;
          end
        end else if (done_cond) begin
          if (out_free) begin
            // Empty merge end: marker result.
            out_push               = 1'b1;
            push_data.kind         = KIND_DATA;
            push_data.merged_value = '0;
            push_data.source_list  = item_id_q;
            push_data.last_of_run  = 1'b1;
            push_data.merge_done   = 1'b1;
            closed_d               = '0;
            state_d                = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      closed_q   <= '0;
      pend_vld_q <= 1'b0;
      drop_q     <= 1'b0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < LISTS; i++) begin
        fill_q[i] <= '0;
        rp_q[i]   <= '0;
      end
    end else begin
      state_q    <= state_d;
      closed_q   <= closed_d;
      pend_vld_q <= pend_vld_d;
      drop_q     <= drop_d;
      scan_q     <= scan_d;
      rd_vld_q   <= rd_vld_d;
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_push || (out_vld_q && out_stall_i);
      fill_q     <= fill_d;
      rp_q       <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    item_id_q  <= item_id_d;
    rd_list_q  <= rd_list_d;
    best_val_q <= best_val_d;
    best_id_q  <= best_id_d;
    if (out_push) begin
      out_q <= push_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= q_data_i.value;
    end
    rd_data_q <= mem[mem_raddr];
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `KWM_ASSERT_IMP(a_put_has_min, state_q == S_PUT, best_vld_q, "emit without a minimum")
  `KWM_ASSERT_IMP(a_pop_clean, q_pop_o, !pend_vld_q && !rd_vld_q, "item taken mid merge")
  `KWM_ASSERT_NXT(a_done_clears, out_push && push_data.merge_done, closed_q == '0, "marks kept")
  `KWM_ASSERT_IMP(a_done_last, out_push && push_data.merge_done, push_data.last_of_run,
                  "merge end not on last result")

endmodule

`default_nettype wire

// ===== src/k_way_sorted_merge_unit.sv =====
// Path: an accepted item waits in the two-entry queue until the merge engine is idle;
//   each merged value (n = lists in use) takes a check, n head reads and a select.
// Flow: one item at a time in the engine; a drop goes straight to the end step, an item
//   with R results runs check, scan and select once per result; output stalls hold it.
// Reset: rst_ni low clears fill counts, read pointers, closed marks and sets
//   lists_in_use to 8; buffer memory keeps its contents and needs no clearing pass.
`default_nettype none

module k_way_sorted_merge_unit #(
  parameter int LISTS        = 8,
  parameter int BUFFER_DEPTH = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [kwm_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire kwm_pkg::in_item_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output kwm_pkg::out_item_t             out_data_o
);
  import kwm_pkg::*;

  logic             q_push;
  q_entry_t         q_push_data;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  q_entry_t         q_data;
  logic [CFG_W-1:0] n_lists;

  kwm_front #(
    .LISTS (LISTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_push_data),
    .n_lists_o   (n_lists)
  );

  kwm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  kwm_back #(
    .LISTS        (LISTS),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_lists_i   (n_lists),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
